/* hw/rtl/ohlc_pkg.sv */
// Shared types, codes and constants of the OHLC bar aggregator.
package ohlc_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_PERIOD  = 2'd0;
   localparam logic [1:0] CSR_TICK    = 2'd1;
   localparam logic [1:0] CSR_HISTORY = 2'd2;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 11;

   // Configuration reset values
   localparam logic [10:0] PERIOD_RESET  = 11'd1;
   localparam logic        TICK_RESET    = 1'b0;
   localparam logic [8:0]  HISTORY_RESET = 9'd256;

   // Parameter defaults
   localparam int HISTORY_DEPTH_DEFAULT = 256;
   localparam int PRICE_BITS_DEFAULT    = 32;

   // Opcodes
   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_READ   = 1'b1;

   // Result status codes
   localparam logic [1:0] ST_NEW    = 2'd0;
   localparam logic [1:0] ST_EXTEND = 2'd1;
   localparam logic [1:0] ST_READ   = 2'd2;
   localparam logic [1:0] ST_RANGE  = 2'd3;

   // Remainder divider: one quotient bit per cycle over the 32-bit time
   localparam int DIV_STEPS = 32;
   localparam int REM_BITS  = 17;

   // Entries of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic        opcode;
      logic [31:0] bar_time;
      logic [31:0] bar_open;
      logic [31:0] bar_high;
      logic [31:0] bar_low;
      logic [31:0] bar_close;
      logic [7:0]  read_age;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] out_time;
      logic [31:0] out_open;
      logic [31:0] out_high;
      logic [31:0] out_low;
      logic [31:0] out_close;
      logic [8:0]  bar_count;
   } rsp_type;

   // Classified item handed from front to back
   typedef struct packed {
      req_type                req;
      logic [REM_BITS-1:0]    rem;
   } qitem_type;

   typedef struct packed {
      logic      valid;
      qitem_type item;
   } qpush_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

endpackage

/* hw/rtl/ohlc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ohlc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

/* hw/rtl/ohlc_front.sv */
// Front end: accepts transactions and works out the time remainder of updates.
module ohlc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  ohlc_pkg::req_type   req_data,
   input  logic [10:0]         period,
   input  ohlc_pkg::qstat_type q_stat,
   output ohlc_pkg::qpush_type q_push
);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_DIV  = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   localparam int RB = ohlc_pkg::REM_BITS;
   localparam int CB = $clog2(ohlc_pkg::DIV_STEPS);

   logic [1:0]          state_ff, state_in;
   ohlc_pkg::req_type   req_ff, req_in;
   logic [RB-1:0]       per_ff, per_in;
   logic [RB-1:0]       rem_ff, rem_in;
   logic [31:0]         dvd_ff, dvd_in;
   logic [CB-1:0]       cnt_ff, cnt_in;
   logic [RB-1:0]       per_calc;
   logic [RB:0]         trial;

   // Period in seconds: minutes times 60 as (p << 6) - (p << 2)
   assign per_calc = RB'({period, 6'b0}) - RB'({period, 2'b0});

   // One restoring step: bring in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, dvd_ff[31]};

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      per_in   = per_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      cnt_in   = cnt_ff;
      q_push.valid     = 1'b0;
      q_push.item.req  = req_ff;
      q_push.item.rem  = rem_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (start) begin
               req_in = req_data;
               per_in = per_calc;
               rem_in = '0;
               dvd_in = req_data.bar_time;
               cnt_in = '0;
               if (req_data.opcode == ohlc_pkg::OP_READ || per_calc == '0) begin
                  state_in = F_PUSH;
               end else begin
                  state_in = F_DIV;
               end
            end
         end
         F_DIV: begin
            if (trial >= {1'b0, per_ff}) begin
               rem_in = RB'(trial - {1'b0, per_ff});
            end else begin
               rem_in = RB'(trial);
            end
            dvd_in = {dvd_ff[30:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CB'(ohlc_pkg::DIV_STEPS - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            // Hold until the queue has room
            if (!q_stat.full) begin
               q_push.valid = 1'b1;
               state_in     = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      per_ff <= per_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      cnt_ff <= cnt_in;
   end

   assign busy = (state_ff != F_IDLE);

endmodule

/* hw/rtl/ohlc_queue.sv */
// Short queue of classified items between front and back.
module ohlc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  ohlc_pkg::qpush_type  q_push,
   input  logic                 pop,
   output ohlc_pkg::qitem_type  head,
   output ohlc_pkg::qstat_type  q_stat
);

   localparam int DEPTH = ohlc_pkg::QUEUE_DEPTH;
   localparam int PB    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NB    = $clog2(DEPTH + 1);

   ohlc_pkg::qitem_type entry_ff [DEPTH];
   logic [PB-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [NB-1:0]       fill_ff, fill_in;
   logic                do_push, do_pop;

   assign q_stat.empty = (fill_ff == '0);
   assign q_stat.full  = (fill_ff == NB'(DEPTH));
   assign do_push      = q_push.valid && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign head         = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PB'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PB'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_push.item;
      end
   end

endmodule

/* hw/rtl/ohlc_back.sv */
// Back end: bar history store, new/extend decision and result generation.
module ohlc_back #(
   parameter int HISTORY_DEPTH = ohlc_pkg::HISTORY_DEPTH_DEFAULT,
   parameter int PRICE_BITS    = ohlc_pkg::PRICE_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ohlc_pkg::qitem_type  head,
   input  ohlc_pkg::qstat_type  q_stat,
   output logic                 pop,
   input  logic                 tick_mode,
   input  logic [8:0]           history_size,
   output logic                 rsp_valid,
   output ohlc_pkg::rsp_type    rsp_data
);

   localparam logic [1:0] B_IDLE  = 2'd0;
   localparam logic [1:0] B_READ  = 2'd1;
   localparam logic [1:0] B_MERGE = 2'd2;

   localparam int IW = $clog2(HISTORY_DEPTH);
   localparam int SW = IW + 2;
   localparam int PB = PRICE_BITS;
   localparam int RW = 32 + 4 * PB;
   localparam int RB = ohlc_pkg::REM_BITS;

   logic [1:0]          state_ff, state_in;
   ohlc_pkg::qitem_type item_ff, item_in;
   logic [IW-1:0]       newest_ff, newest_in;
   logic [8:0]          count_ff, count_in;
   logic [RB-1:0]       prev_ff, prev_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ohlc_pkg::rsp_type   rsp_ff, rsp_in;

   logic                wr_en, rd_en;
   logic [IW-1:0]       wr_addr, rd_addr;
   logic [RW-1:0]       wr_row, rd_row;

   logic [8:0]          limit;
   logic [9:0]          grown;
   logic [8:0]          grown_count;
   logic [IW-1:0]       next_slot;
   logic [SW-1:0]       back_sum;
   logic [IW-1:0]       read_slot;
   logic                start_new;

   logic [PB-1:0]       rd_high, rd_low;
   logic [PB-1:0]       in_high, in_low;

   function automatic logic [PB-1:0] to_price(input logic [31:0] v);
      return PB'(64'(v));
   endfunction

   function automatic logic [31:0] from_price(input logic [PB-1:0] p);
      return 32'(64'(p));
   endfunction

   ohlc_ram #(
      .WIDTH (RW),
      .DEPTH (HISTORY_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_row)
   );

   // Size limit: zero acts as one, clamp at the ring depth
   always_comb begin
      if (history_size == '0) begin
         limit = 9'd1;
      end else if (32'(history_size) > 32'(HISTORY_DEPTH)) begin
         limit = 9'(HISTORY_DEPTH);
      end else begin
         limit = history_size;
      end
   end

   assign grown       = {1'b0, count_ff} + 10'd1;
   assign grown_count = (grown > {1'b0, limit}) ? limit : 9'(grown);
   assign next_slot   = (newest_ff == IW'(HISTORY_DEPTH - 1)) ? '0 : newest_ff + 1'b1;

   // Slot of a bar by age, stepping back around the ring
   assign back_sum  = SW'(newest_ff) + SW'(HISTORY_DEPTH) - SW'(head.req.read_age);
   assign read_slot = (back_sum >= SW'(HISTORY_DEPTH)) ?
                      IW'(back_sum - SW'(HISTORY_DEPTH)) : IW'(back_sum);

   assign start_new = tick_mode || (head.rem < prev_ff) || (count_ff == '0);

   assign rd_high = rd_row[3*PB-1:2*PB];
   assign rd_low  = rd_row[2*PB-1:PB];
   assign in_high = to_price(item_ff.req.bar_high);
   assign in_low  = to_price(item_ff.req.bar_low);

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      newest_in    = newest_ff;
      count_in     = count_ff;
      prev_in      = prev_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = newest_ff;
      wr_row       = '0;
      rd_en        = 1'b0;
      rd_addr      = newest_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_stat.empty) begin
               pop     = 1'b1;
               item_in = head;
               if (head.req.opcode == ohlc_pkg::OP_READ) begin
                  if ({1'b0, head.req.read_age} < count_ff) begin
                     rd_en    = 1'b1;
                     rd_addr  = read_slot;
                     state_in = B_READ;
                  end else begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.status    = ohlc_pkg::ST_RANGE;
                     rsp_in.bar_count = count_ff;
                  end
               end else begin
                  prev_in = head.rem;
                  if (start_new) begin
                     // Open a new bar in the next ring slot
                     wr_en     = 1'b1;
                     wr_addr   = next_slot;
                     wr_row    = {head.req.bar_time,
                                  to_price(head.req.bar_open),
                                  to_price(head.req.bar_high),
                                  to_price(head.req.bar_low),
                                  to_price(head.req.bar_close)};
                     newest_in = next_slot;
                     count_in  = grown_count;
                     rsp_valid_in     = 1'b1;
                     rsp_in.status    = ohlc_pkg::ST_NEW;
                     rsp_in.bar_count = grown_count;
                  end else begin
                     // Fetch the newest bar for the merge
                     rd_en    = 1'b1;
                     rd_addr  = newest_ff;
                     state_in = B_MERGE;
                  end
               end
            end
         end
         B_READ: begin
            rsp_valid_in     = 1'b1;
            rsp_in.status    = ohlc_pkg::ST_READ;
            rsp_in.out_time  = rd_row[RW-1:4*PB];
            rsp_in.out_open  = from_price(rd_row[4*PB-1:3*PB]);
            rsp_in.out_high  = from_price(rd_high);
            rsp_in.out_low   = from_price(rd_low);
            rsp_in.out_close = from_price(rd_row[PB-1:0]);
            rsp_in.bar_count = count_ff;
            state_in         = B_IDLE;
         end
         B_MERGE: begin
            // Overwrite close, widen high and low, keep time and open
            wr_en   = 1'b1;
            wr_addr = newest_ff;
            wr_row  = {rd_row[RW-1:3*PB],
                       (rd_high < in_high) ? in_high : rd_high,
                       (rd_low > in_low) ? in_low : rd_low,
                       to_price(item_ff.req.bar_close)};
            rsp_valid_in     = 1'b1;
            rsp_in.status    = ohlc_pkg::ST_EXTEND;
            rsp_in.bar_count = count_ff;
            state_in         = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         newest_ff    <= '0;
         count_ff     <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         newest_ff    <= newest_in;
         count_ff     <= count_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hw/rtl/ohlc_bar_aggregator_core.sv */
// Top level of the OHLC time-bar aggregator.
//
//  channel   ports                                 transfer
//  request   start, busy, req_data                 start && !busy
//  response  rsp_valid, rsp_data                   rsp_valid, one cycle each
//  csr       csr_write_en, csr_index, csr_wdata    csr_write_en
//
// An update runs 32 steps in the one-bit-per-cycle remainder divider, is then
// pushed into the queue (held while it is full) and handled by the back end: a
// new bar is written directly, an extend first reads the history RAM. A zero
// period skips the divider, as a read does; a read in range first reads the RAM.
// busy stays high while the front end holds a transaction. Reset is synchronous
// and clears the history count; no RAM clearing pass. Responses cannot stall.
module ohlc_bar_aggregator_core #(
   parameter int HISTORY_DEPTH = ohlc_pkg::HISTORY_DEPTH_DEFAULT,
   parameter int PRICE_BITS    = ohlc_pkg::PRICE_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  ohlc_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   output ohlc_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_write_en,
   input  logic [ohlc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ohlc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   logic [10:0]          period_ff;
   logic                 tick_ff;
   logic [8:0]           history_ff;

   ohlc_pkg::qpush_type  q_push;
   ohlc_pkg::qstat_type  q_stat;
   ohlc_pkg::qitem_type  q_head;
   logic                 q_pop;

   // Configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= ohlc_pkg::PERIOD_RESET;
         tick_ff    <= ohlc_pkg::TICK_RESET;
         history_ff <= ohlc_pkg::HISTORY_RESET;
      end else if (csr_write_en) begin
         if (csr_index == ohlc_pkg::CSR_PERIOD) begin
            period_ff <= csr_wdata[10:0];
         end
         if (csr_index == ohlc_pkg::CSR_TICK) begin
            tick_ff <= csr_wdata[0];
         end
         if (csr_index == ohlc_pkg::CSR_HISTORY) begin
            history_ff <= csr_wdata[8:0];
         end
      end
   end

   ohlc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .period   (period_ff),
      .q_stat   (q_stat),
      .q_push   (q_push)
   );

   ohlc_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .pop    (q_pop),
      .head   (q_head),
      .q_stat (q_stat)
   );

   ohlc_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .PRICE_BITS    (PRICE_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (q_head),
      .q_stat       (q_stat),
      .pop          (q_pop),
      .tick_mode    (tick_ff),
      .history_size (history_ff),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

endmodule

/* tb/ohlc_bar_aggregator_core_tb.sv */
// Testbench for the OHLC bar aggregator core: directed and random transactions checked against a bar model.
`timescale 1ns / 100ps

module ohlc_bar_aggregator_core_tb;
   import ohlc_pkg::*;

   localparam int          DEPTH        = HISTORY_DEPTH_DEFAULT;
   localparam int          DRAIN_CYCLES = 50;
   localparam logic [31:0] PRICE_MAX    = 32'hFFFF_FFFF;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   req_type                   req_data;
   logic                      rsp_valid;
   rsp_type                   rsp_data;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   // Bar history model
   logic [31:0]         store_time  [DEPTH];
   logic [31:0]         store_open  [DEPTH];
   logic [31:0]         store_high  [DEPTH];
   logic [31:0]         store_low   [DEPTH];
   logic [31:0]         store_close [DEPTH];
   logic [7:0]          newest_bar;
   logic [8:0]          held_bars;
   logic [REM_BITS-1:0] last_rem;
   logic [10:0]         cfg_period;
   logic                cfg_tick;
   logic [8:0]          cfg_history;

   rsp_type     expected_bars [$];
   int          mismatch_count;
   int          burst_left;
   logic [31:0] feed_time;

   ohlc_bar_aggregator_core uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Fold one transaction into the bar history and return the response it yields
   function automatic rsp_type aggregate_bar(input req_type item);
      rsp_type             r;
      logic [31:0]         period_sec;
      logic [31:0]         full_rem;
      logic [REM_BITS-1:0] rem;
      logic [8:0]          limit;
      logic [7:0]          slot;
      r = '0;
      if (item.opcode == OP_UPDATE) begin
         period_sec = {21'd0, cfg_period} * 32'd60;
         full_rem = (period_sec == 32'd0) ? 32'd0 : item.bar_time % period_sec;
         rem = full_rem[REM_BITS-1:0];
         if (cfg_tick || rem < last_rem || held_bars == 9'd0) begin
            // Open a new bar in the next ring slot, clamp the count to the size limit
            if (cfg_history == 9'd0)
               limit = 9'd1;
            else if (cfg_history > 9'(DEPTH))
               limit = 9'(DEPTH);
            else
               limit = cfg_history;
            slot = newest_bar + 8'd1;
            store_time[slot]  = item.bar_time;
            store_open[slot]  = item.bar_open;
            store_high[slot]  = item.bar_high;
            store_low[slot]   = item.bar_low;
            store_close[slot] = item.bar_close;
            newest_bar = slot;
            held_bars = (held_bars + 9'd1 > limit) ? limit : held_bars + 9'd1;
            r.status = ST_NEW;
         end else begin
            // Extend the newest bar
            slot = newest_bar;
            store_close[slot] = item.bar_close;
            if (store_high[slot] < item.bar_high)
               store_high[slot] = item.bar_high;
            if (store_low[slot] > item.bar_low)
               store_low[slot] = item.bar_low;
            r.status = ST_EXTEND;
         end
         last_rem = rem;
      end else begin
         if ({1'b0, item.read_age} < held_bars) begin
            slot = newest_bar - item.read_age;
            r.out_time  = store_time[slot];
            r.out_open  = store_open[slot];
            r.out_high  = store_high[slot];
            r.out_low   = store_low[slot];
            r.out_close = store_close[slot];
            r.status    = ST_READ;
         end else begin
            r.status = ST_RANGE;
         end
      end
      r.bar_count = held_bars;
      return r;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatch_count++;
      end
   endtask

   // Compare each response against the oldest expected bar
   always @(posedge clock) begin
      rsp_type want;
      if (reset !== 1'b1 && rsp_valid !== 1'b0) begin
         if (expected_bars.size() == 0) begin
            $error("response with no transaction outstanding: %0h", rsp_data);
            mismatch_count++;
         end else begin
            want = expected_bars.pop_front();
            check_field("status", {30'd0, want.status}, {30'd0, rsp_data.status});
            check_field("out_time", want.out_time, rsp_data.out_time);
            check_field("out_open", want.out_open, rsp_data.out_open);
            check_field("out_high", want.out_high, rsp_data.out_high);
            check_field("out_low", want.out_low, rsp_data.out_low);
            check_field("out_close", want.out_close, rsp_data.out_close);
            check_field("bar_count", {23'd0, want.bar_count}, {23'd0, rsp_data.bar_count});
         end
      end
   end

   // Send one transaction, record its expected response, then maybe idle
   task automatic send_item(input req_type item);
      int gap;
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      expected_bars.push_back(aggregate_bar(item));
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
   endtask

   // Drop start and wait for every outstanding response
   task automatic wait_idle();
      start <= 1'b0;
      while (expected_bars.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_PERIOD:  cfg_period = value;
         CSR_TICK:    cfg_tick = value[0];
         CSR_HISTORY: cfg_history = value[8:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [10:0] period, input logic [10:0] tick_value,
                            input logic [10:0] history);
      wait_idle();
      write_csr(CSR_PERIOD, period);
      write_csr(CSR_TICK, tick_value);
      write_csr(CSR_HISTORY, history);
   endtask

   function automatic logic [31:0] rand_price();
      case ($urandom_range(0, 7))
         0:       return 32'd0;
         1:       return PRICE_MAX;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type make_bar(input logic [31:0] t, input logic [31:0] o,
                                        input logic [31:0] h, input logic [31:0] l,
                                        input logic [31:0] c);
      req_type item;
      item.opcode    = OP_UPDATE;
      item.bar_time  = t;
      item.bar_open  = o;
      item.bar_high  = h;
      item.bar_low   = l;
      item.bar_close = c;
      item.read_age  = 8'($urandom);
      return item;
   endfunction

   function automatic req_type make_update(input logic [31:0] t);
      return make_bar(t, rand_price(), rand_price(), rand_price(), rand_price());
   endfunction

   function automatic req_type make_read(input logic [7:0] age);
      req_type item;
      item = make_update($urandom);
      item.opcode   = OP_READ;
      item.read_age = age;
      return item;
   endfunction

   // Read an empty store at both ends of the age range
   task automatic test_empty_store();
      send_item(make_read(8'd0));
      send_item(make_read(8'hFF));
   endtask

   // Start, extend and roll over bars with the reset period of one minute
   task automatic test_bar_extend();
      send_item(make_bar(32'd0, 32'd100, 32'd200, 32'd50, 32'd150));
      send_item(make_bar(32'd10, 32'd0, 32'd300, 32'd40, 32'd160));
      send_item(make_bar(32'd20, PRICE_MAX, 32'd250, 32'd45, 32'd0));
      send_item(make_bar(32'd59, 32'd0, PRICE_MAX, 32'd0, PRICE_MAX));
      send_item(make_bar(32'd60, 32'd1, 32'd2, PRICE_MAX, 32'd3));
      send_item(make_bar(PRICE_MAX, PRICE_MAX, 32'd0, PRICE_MAX, 32'd7));
      send_item(make_read(8'd0));
      send_item(make_read(8'd1));
      send_item(make_read(8'd2));
   endtask

   // Zero period: the remainder is zero, so after the first update opens a bar the next one extends
   task automatic test_zero_period();
      configure(11'd0, 11'd0, 11'd256);
      send_item(make_update($urandom));
      send_item(make_update(32'd0));
      send_item(make_read(8'd0));
   endtask

   // Tick mode: every update opens a bar, even at the same timestamp
   task automatic test_tick_mode();
      configure(11'd1, 11'd1, 11'd256);
      repeat (3) send_item(make_update(32'd30));
      send_item(make_read(8'd2));
   endtask

   // History size of zero acts as one, oversize acts as the full depth
   task automatic test_history_bounds();
      configure(11'd1, 11'd1, 11'd0);
      repeat (2) send_item(make_update($urandom));
      send_item(make_read(8'd1));
      configure(11'h7FF, 11'h7FF, 11'h7FF);
      send_item(make_update($urandom));
      send_item(make_read(8'd0));
   endtask

   // Shrinking the size keeps old bars readable until the next new bar
   task automatic test_shrink();
      configure(11'd1, 11'd1, 11'd8);
      repeat (5) send_item(make_update($urandom));
      configure(11'd1, 11'd1, 11'd3);
      send_item(make_read(8'd4));
      send_item(make_update($urandom));
      send_item(make_read(8'd3));
      send_item(make_read(8'd2));
   endtask

   // Mostly rising timestamps within and across bars, reads near the count, some noise
   task automatic run_random_phase(input logic [10:0] period, input logic [10:0] tick_value,
                                   input logic [10:0] history, input int count);
      int      kind;
      int      span;
      int      age_top;
      req_type item;
      configure(period, tick_value, history);
      span = (cfg_period == 11'd0) ? 60 : int'(cfg_period) * 60;
      feed_time = ($urandom_range(0, 3) == 0) ? PRICE_MAX - $urandom_range(0, 4 * span)
                                              : $urandom;
      repeat (count) begin
         kind = $urandom_range(0, 99);
         age_top = (held_bars > 9'd255) ? 255 : int'(held_bars);
         if (kind < 62) begin
            if ($urandom_range(0, 9) == 0)
               feed_time += $urandom_range(span, 3 * span);
            else
               feed_time += $urandom_range(0, span / 4 + 1);
            item = make_update(feed_time);
         end else if (kind < 90) begin
            item = make_read(8'($urandom_range(0, age_top)));
         end else if (kind < 95) begin
            item = make_update($urandom);
         end else begin
            item = make_read(8'($urandom));
         end
         send_item(item);
      end
   endtask

   task automatic test_random_traffic();
      int n;
      run_random_phase(11'd1, 11'd0, 11'd256, 250);
      run_random_phase(11'd1440, 11'd0, 11'd256, 200);
      run_random_phase(11'd2047, 11'd1, 11'd256, 300);
      run_random_phase(11'd0, 11'd0, 11'd4, 100);
      run_random_phase(11'd5, 11'd0, 11'd0, 150);
      run_random_phase(11'd3, 11'd0, 11'd511, 200);
      // Finish with a few random settings, mostly short periods
      for (n = 0; n < 3; n++) begin
         run_random_phase(($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 2047))
                                                      : 11'($urandom_range(1, 10)),
                          11'($urandom), 11'($urandom), 200);
      end
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      csr_write_en <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      cfg_period = PERIOD_RESET;
      cfg_tick = TICK_RESET;
      cfg_history = HISTORY_RESET;
      newest_bar = '0;
      held_bars = '0;
      last_rem = '0;
      mismatch_count = 0;
      burst_left = 1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_store();
      test_bar_extend();
      test_zero_period();
      test_tick_mode();
      test_history_bounds();
      test_shrink();
      test_random_traffic();

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Stop a hung run
   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
